// File: rtl/bdq_pkg.sv
// ----------------------------------------------------------------------------
// bdq_pkg
// Shared types and constants for the bounded double-ended queue engine.
// ----------------------------------------------------------------------------
`default_nettype none

package bdq_pkg;

  localparam int unsigned DefaultDepth     = 1024;
  localparam int unsigned DefaultDataWidth = 32;
  localparam int unsigned ValueWidth       = 32;

  typedef enum logic [2:0] {
    CMD_PUSH_FRONT = 3'd0,
    CMD_PUSH_BACK  = 3'd1,
    CMD_POP_FRONT  = 3'd2,
    CMD_POP_BACK   = 3'd3,
    CMD_SIZE       = 3'd4,
    CMD_EMPTY      = 3'd5,
    CMD_PEEK_FRONT = 3'd6,
    CMD_PEEK_BACK  = 3'd7
  } cmd_code_t;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_FULL  = 2'd2
  } status_code_t;

  typedef enum logic {
    S_IDLE   = 1'b0,
    S_FINISH = 1'b1
  } ctrl_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;    // take the request on the ports this cycle
    logic load_out;  // move the pending result into the output register
  } dq_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic has_result;  // the request on the ports would give a result
  } dq_status_t;

endpackage

`default_nettype wire

// File: rtl/bounded_deque_engine_top.sv
// ----------------------------------------------------------------------------
// bounded_deque_engine_top
// Bounded double-ended queue of signed words in a circular store.
//
//   Channel   Handshake               Payload
//   request   req_valid / req_ready   req_type, item_value
//   response  rsp_valid / rsp_ready   out_value, out_status
//
// A push that fits is taken at once and gives no response. Every other
// request is accepted in the idle state, in which the store is read at its
// single read port, and then moves to the finish state, in which the result is
// formed and loaded into the output register once that register is free.
// A request is accepted while an earlier response waits to be taken.
// Reset (synchronous, active high) empties the deque; the store itself is not
// cleared, as only live entries are ever read, so no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module bounded_deque_engine_top
  import bdq_pkg::*;
#(
  parameter int unsigned DEPTH      = DefaultDepth,
  parameter int unsigned DATA_WIDTH = DefaultDataWidth
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         req_valid,
  output logic                              req_ready,
  input  wire logic [2:0]                   req_type,
  input  wire logic signed [ValueWidth-1:0] item_value,
  output logic                              rsp_valid,
  input  wire logic                         rsp_ready,
  output logic signed [ValueWidth-1:0]      out_value,
  output logic [1:0]                        out_status
);

  // The controller decides when a request is taken and when its result moves
  // to the output register; the datapath owns the pointers and the store.
  dq_cmd_t    cmd;
  dq_status_t status;

  bdq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .cmd       (cmd),
    .status    (status)
  );

  bdq_datapath #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .status     (status),
    .req_type   (req_type),
    .item_value (item_value),
    .out_value  (out_value),
    .out_status (out_status)
  );

endmodule

`default_nettype wire

// File: rtl/bdq_ram.sv
// ----------------------------------------------------------------------------
// bdq_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module bdq_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// File: rtl/bdq_ctrl.sv
// ----------------------------------------------------------------------------
// bdq_ctrl
// Controller: request acceptance, result sequencing and output valid.
// ----------------------------------------------------------------------------
`default_nettype none

module bdq_ctrl
  import bdq_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       req_valid,
  output logic            req_ready,
  output logic            rsp_valid,
  input  wire logic       rsp_ready,
  output dq_cmd_t         cmd,
  input  wire dq_status_t status
);

  ctrl_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next   = state;
    cmd          = '0;
    req_ready    = (state == S_IDLE);
    cmd.accept   = req_valid && req_ready;
    case (state)
      S_IDLE: begin
        if (cmd.accept && status.has_result) begin
          state_next = S_FINISH;
        end
      end
      S_FINISH: begin
        // The output register is free, or is being emptied this cycle.
        if (!rsp_valid || rsp_ready) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.load_out) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  // A pending result lands in the output register as soon as it is free.
  a_finish_drains: assert property (@(posedge clk) disable iff (rst)
    (state == S_FINISH && !(rsp_valid && !rsp_ready)) |=> (state == S_IDLE && rsp_valid))
    else $error("pending result not moved to the output register");

endmodule

`default_nettype wire

// File: rtl/bdq_datapath.sv
// ----------------------------------------------------------------------------
// bdq_datapath
// Datapath: head and count registers, store addressing, result registers.
// ----------------------------------------------------------------------------
`default_nettype none

module bdq_datapath
  import bdq_pkg::*;
#(
  parameter int unsigned DEPTH      = DefaultDepth,
  parameter int unsigned DATA_WIDTH = DefaultDataWidth
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire dq_cmd_t                      cmd,
  output dq_status_t                        status,
  input  wire logic [2:0]                   req_type,
  input  wire logic signed [ValueWidth-1:0] item_value,
  output logic signed [ValueWidth-1:0]      out_value,
  output logic [1:0]                        out_status
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned SW = CW + 1;

  logic [AW-1:0] head, head_next;
  logic [CW-1:0] count, count_next;

  logic          full, empty;
  logic          is_push, is_read;
  logic [SW-1:0] tail_sum, back_sum;
  logic [AW-1:0] tail_slot, back_slot, head_dec, head_inc;

  logic                  wr_en, rd_en;
  logic [AW-1:0]         wr_addr, rd_addr;
  logic [DATA_WIDTH-1:0] wr_data, rd_data;
  logic signed [63:0]    word_in64, word_out64;

  // Result waiting for the output register.
  logic                  res_from_ram;
  logic [ValueWidth-1:0] res_direct;
  status_code_t          res_status;
  logic                  res_from_ram_next;
  logic [ValueWidth-1:0] res_direct_next;
  status_code_t          res_status_next;

  cmd_code_t code;

  assign code  = cmd_code_t'(req_type);
  assign full  = (count == CW'(DEPTH));
  assign empty = (count == '0);

  // Slot after the back entry and the back entry itself, wrapped once.
  assign tail_sum  = SW'(head) + SW'(count);
  assign back_sum  = SW'(head) + SW'(count) - SW'(1);
  assign tail_slot = (tail_sum >= SW'(DEPTH)) ? AW'(tail_sum - SW'(DEPTH)) : AW'(tail_sum);
  assign back_slot = (back_sum >= SW'(DEPTH)) ? AW'(back_sum - SW'(DEPTH)) : AW'(back_sum);
  assign head_dec  = (head == '0) ? AW'(DEPTH - 1) : head - AW'(1);
  assign head_inc  = (head == AW'(DEPTH - 1)) ? '0 : head + AW'(1);

  assign is_push = (code == CMD_PUSH_FRONT) || (code == CMD_PUSH_BACK);
  assign is_read = (code inside {CMD_POP_FRONT, CMD_POP_BACK, CMD_PEEK_FRONT, CMD_PEEK_BACK});

  assign status.has_result = !(is_push && !full);

  assign word_in64 = 64'(item_value);
  assign wr_data   = word_in64[DATA_WIDTH-1:0];

  always_comb begin
    head_next         = head;
    count_next        = count;
    wr_en             = 1'b0;
    wr_addr           = tail_slot;
    rd_en             = 1'b0;
    rd_addr           = head;
    res_from_ram_next = 1'b0;
    res_direct_next   = '0;
    res_status_next   = STAT_OK;
    if (is_push && full) begin
      res_status_next = STAT_FULL;
    end else if (is_read && empty) begin
      res_direct_next = '1;
      res_status_next = STAT_EMPTY;
    end
    case (code)
      CMD_PUSH_FRONT: begin
        if (!full) begin
          head_next  = head_dec;
          wr_en      = 1'b1;
          wr_addr    = head_dec;
          count_next = count + CW'(1);
        end
      end
      CMD_PUSH_BACK: begin
        if (!full) begin
          wr_en      = 1'b1;
          wr_addr    = tail_slot;
          count_next = count + CW'(1);
        end
      end
      CMD_POP_FRONT: begin
        if (!empty) begin
          rd_en             = 1'b1;
          rd_addr           = head;
          res_from_ram_next = 1'b1;
          head_next         = head_inc;
          count_next        = count - CW'(1);
        end
      end
      CMD_POP_BACK: begin
        if (!empty) begin
          rd_en             = 1'b1;
          rd_addr           = back_slot;
          res_from_ram_next = 1'b1;
          count_next        = count - CW'(1);
        end
      end
      CMD_SIZE: begin
        res_direct_next = ValueWidth'(count);
      end
      CMD_EMPTY: begin
        res_direct_next = ValueWidth'(empty);
      end
      CMD_PEEK_FRONT: begin
        if (!empty) begin
          rd_en             = 1'b1;
          rd_addr           = head;
          res_from_ram_next = 1'b1;
        end
      end
      CMD_PEEK_BACK: begin
        if (!empty) begin
          rd_en             = 1'b1;
          rd_addr           = back_slot;
          res_from_ram_next = 1'b1;
        end
      end
      default: begin
        head_next = head;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      count <= '0;
    end else if (cmd.accept) begin
      head  <= head_next;
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      res_from_ram <= res_from_ram_next;
      res_direct   <= res_direct_next;
      res_status   <= res_status_next;
    end
  end

  bdq_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (cmd.accept && wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (cmd.accept && rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // A stored word is answered sign-extended from its own width.
  assign word_out64 = 64'(signed'(rd_data));

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_value  <= res_from_ram ? word_out64[ValueWidth-1:0] : res_direct;
      out_status <= res_status;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    (count <= CW'(DEPTH)) && (head <= AW'(DEPTH - 1)))
    else $error("entry count or head index out of range");

  a_full_push_kept: assert property (@(posedge clk) disable iff (rst)
    (cmd.accept && is_push && full) |=> ($stable(count) && $stable(head)))
    else $error("push into a full deque changed the state");

  a_pop_shrinks: assert property (@(posedge clk) disable iff (rst)
    (cmd.accept && !empty && (code == CMD_POP_FRONT || code == CMD_POP_BACK))
      |=> (count == $past(count) - CW'(1)))
    else $error("pop did not remove exactly one entry");

endmodule

`default_nettype wire
